@@ src/updc_pkg.sv @@
// ---------------------------------------------------------------------------
// updc_pkg: shared types and helpers for the uri percent-decode checker
// word formats on both channels, the internal op format and byte classifiers
// ---------------------------------------------------------------------------
package updc_pkg;

  localparam logic [7:0] PERCENT_CHAR = 8'h25;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } updc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       byte_allowed;
    logic       uri_ok;
  } updc_out_t;

  // one op is one or two decoded bytes; a pair is '%' then byte_b
  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       pair;
    logic       last;
  } updc_op_t;

  // returns {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] decode_pair(input logic [7:0] first,
                                             input logic [7:0] second);
    logic [4:0] d1;
    logic [4:0] d2;
    logic [7:0] r;
    d1 = hex_nibble(first);
    d2 = hex_nibble(second);
    if (!d1[4]) begin
      r = 8'h00;
    end else if (!d2[4]) begin
      r = {4'h0, d1[3:0]};
    end else begin
      r = {d1[3:0], d2[3:0]};
    end
    return r;
  endfunction

  function automatic logic char_allowed(input logic [7:0] c);
    logic r;
    r = 1'b0;
    if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
        (c >= 8'h30 && c <= 8'h39)) begin
      r = 1'b1;
    end else begin
      case (c)
        8'h2d, 8'h2e, 8'h5f, 8'h7e, 8'h3a, 8'h2f, 8'h3f, 8'h23,
        8'h5b, 8'h5d, 8'h40, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28,
        8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d, 8'h25: r = 1'b1;
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

@@ src/updc_front.sv @@
// ---------------------------------------------------------------------------
// updc_front: escape parser
// tracks '%' escapes and turns each accepted word into zero or one op
// ---------------------------------------------------------------------------
module updc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  updc_pkg::updc_in_t in_i,
  output logic               op_valid_o,
  output updc_pkg::updc_op_t op_o
);
  import updc_pkg::*;

  typedef enum logic [1:0] {
    P_IDLE = 2'd0,
    P_ONE  = 2'd1,
    P_TWO  = 2'd2
  } pend_e;

  pend_e      pend_q, pend_d;
  logic [7:0] held_q, held_d;

  always_comb begin
    pend_d        = pend_q;
    held_d        = held_q;
    op_valid_o    = 1'b0;
    op_o.byte_a   = in_i.in_byte;
    op_o.byte_b   = in_i.in_byte;
    op_o.pair     = 1'b0;
    op_o.last     = in_i.in_last;
    case (pend_q)
      P_ONE: begin
        if (in_i.in_last) begin
          // short escape at end: literal '%' then the byte
          op_valid_o  = 1'b1;
          op_o.byte_a = PERCENT_CHAR;
          op_o.pair   = 1'b1;
        end else begin
          held_d = in_i.in_byte;
          pend_d = P_TWO;
        end
      end
      P_TWO: begin
        op_valid_o  = 1'b1;
        op_o.byte_a = decode_pair(held_q, in_i.in_byte);
        pend_d      = P_IDLE;
        held_d      = 8'h00;
      end
      default: begin
        if (in_i.in_byte == PERCENT_CHAR && !in_i.in_last) begin
          pend_d = P_ONE;
        end else begin
          pend_d     = P_IDLE;
          op_valid_o = 1'b1;
        end
      end
    endcase
    if (in_i.in_last) begin
      pend_d = P_IDLE;
      held_d = 8'h00;
    end
    op_valid_o = op_valid_o & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= P_IDLE;
      held_q <= 8'h00;
    end else if (accept_i) begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

endmodule

@@ src/updc_queue.sv @@
// ---------------------------------------------------------------------------
// updc_queue: op queue
// small register queue between the escape parser and the output stage
// ---------------------------------------------------------------------------
module updc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  updc_pkg::updc_op_t wr_data_i,
  output logic               full_o,
  input  logic               rd_i,
  output logic               valid_o,
  output updc_pkg::updc_op_t rd_data_o
);
  import updc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  updc_op_t      mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == FULL_CNT);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/updc_back.sv @@
// ---------------------------------------------------------------------------
// updc_back: output stage
// splits ops into words, checks each byte and keeps the running uri flag
// ---------------------------------------------------------------------------
module updc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  updc_pkg::updc_op_t  op_i,
  output logic                op_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output updc_pkg::updc_out_t out_o
);
  import updc_pkg::*;

  logic      out_valid_q;
  updc_out_t out_q;
  logic      half_q;
  logic      all_q;
  logic      load;
  logic      first_of_pair;
  logic [7:0] sel_byte;
  logic      sel_last;
  logic      ok;
  logic      uri;

  assign load          = !out_valid_q || pop_i;
  assign first_of_pair = op_i.pair && !half_q;
  assign sel_byte      = (op_i.pair && half_q) ? op_i.byte_b : op_i.byte_a;
  assign sel_last      = first_of_pair ? 1'b0 : op_i.last;
  assign ok            = char_allowed(sel_byte);
  assign uri           = all_q & ok;
  assign op_pop_o      = load && op_valid_i && !first_of_pair;
  assign empty_o       = !out_valid_q;
  assign out_o         = out_q;

  always_ff @(posedge clk_i) begin
    if (load && op_valid_i) begin
      out_q <= '{out_byte: sel_byte, out_last: sel_last, byte_allowed: ok, uri_ok: uri};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
      all_q       <= 1'b1;
    end else if (load) begin
      out_valid_q <= op_valid_i;
      if (op_valid_i) begin
        half_q <= first_of_pair;
        // flag restarts after the last byte of a uri
        all_q  <= sel_last ? 1'b1 : uri;
      end
    end
  end

endmodule

@@ src/uri_percent_decode_check_top.sv @@
// ---------------------------------------------------------------------------
// uri_percent_decode_check_top: streaming uri percent-decoder and checker
// raw uri bytes in, decoded bytes out with per-byte and per-uri validity
// ---------------------------------------------------------------------------
// input channel: a word (byte plus last mark) is taken when push is high and
//   full is low. full rises only when the op queue is full.
// output channel: the oldest decoded word sits on out_data_o while empty is
//   low; it is taken when pop is high.
// a '%' and the byte after it give no word until the second escape byte;
// a short escape at the end of a uri gives two words for one input word.
// path: a word that produces output is written into the op queue when it is
//   taken, then moves into the output register once that register is free.
// throughput: one word per cycle each side while neither side is stalled;
//   the two-word case goes out one word at a time through the single output register.
// stalls on the output side fill the queue, then full holds off the input.
// reset empties the queue and output register, clears any pending escape
//   and sets the running uri flag.
// ---------------------------------------------------------------------------
module uri_percent_decode_check_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  updc_pkg::updc_in_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output updc_pkg::updc_out_t out_data_o
);
  import updc_pkg::*;

  logic     accept;
  logic     op_valid;
  updc_op_t op;
  logic     q_valid;
  updc_op_t q_op;
  logic     q_pop;

  assign accept = push && !full;

  updc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_data_i),
    .op_valid_o (op_valid),
    .op_o       (op)
  );

  updc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (op_valid),
    .wr_data_i (op),
    .full_o    (full),
    .rd_i      (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (q_op)
  );

  updc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (q_op),
    .op_pop_o   (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_data_o)
  );

endmodule

@@ src/updc_checker.sv @@
// ---------------------------------------------------------------------------
// updc_port_checks: port-level checks for the uri decoder
// watches the output channel over time, bound onto the top level
// ---------------------------------------------------------------------------
module updc_port_checks (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty_i,
  input logic                pop_i,
  input updc_pkg::updc_out_t out_data_i
);
  import updc_pkg::*;

  // a waiting word is not withdrawn
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> !empty_i)
    else $error("output word withdrawn before pop");

  // a waiting word does not change
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> $stable(out_data_i))
    else $error("output word changed while stalled");

  // a disallowed byte always spoils the uri flag
  a_bad_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !out_data_i.byte_allowed) |-> !out_data_i.uri_ok)
    else $error("uri_ok set on a disallowed byte");

  // once spoilt, the flag stays low for the next word of the same uri
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && pop_i && !out_data_i.out_last && !out_data_i.uri_ok) ##1 !empty_i
      |-> !out_data_i.uri_ok)
    else $error("uri_ok recovered inside a uri");

endmodule

bind uri_percent_decode_check_top updc_port_checks u_updc_port_checks (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty_i    (empty),
  .pop_i      (pop),
  .out_data_i (out_data_o)
);
